[sv/dmbm_pkg.sv]
// Shared types and constants for the display mode best-match picker.
`timescale 1ns / 1ps

package dmbm_pkg;

  localparam int IDX_W      = 9;
  localparam int SCORE_W    = 28;
  localparam int DIM_W      = 16;
  localparam int RATE_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [IDX_W-1:0]   index_t;

  // One mode of the incoming list.
  typedef struct packed {
    logic [DIM_W-1:0]  mode_width;
    logic [DIM_W-1:0]  mode_height;
    logic [RATE_W-1:0] mode_rate;
    logic              mode_interlaced;
    logic              mode_preferred;
    logic              last_mode;
  } mode_t;

  // Pick for one list.
  typedef struct packed {
    index_t best_index;
    score_t pick_score;
  } result_t;

  // Target registers.
  typedef struct packed {
    logic [DIM_W-1:0]  target_width;
    logic [DIM_W-1:0]  target_height;
    logic [RATE_W-1:0] target_rate;
    logic              target_interlaced;
    logic [1:0]        scoring_rule;
  } cfg_t;

  typedef enum logic [1:0] {
    RULE_PROGRESSIVE = 2'd0,
    RULE_PREFERRED   = 2'd1,
    RULE_INTERLACE   = 2'd2
  } rule_t;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_INTERLACED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORING_RULE      = 3'd4;

  // Score tiers.
  localparam score_t SC_ANY_PREF   = 28'sd83000000;
  localparam score_t SC_ANY_BASE   = 28'sd80000000;
  localparam score_t SC_EXACT      = 28'sd100000000;
  localparam score_t SC_NEAR       = 28'sd95000000;
  localparam score_t SC_DBL_EXACT  = 28'sd90000000;
  localparam score_t SC_DBL_NEAR   = 28'sd85000000;
  localparam score_t SC_SIZE_PEN   = 28'sd30000000;
  localparam score_t SC_SCAN_PEN   = 28'sd20000000;
  localparam score_t SC_PREF_FLOOR = 28'sd10000000;
  localparam score_t SC_NONE       = -28'sd1;
  localparam score_t SC_ONE        = 28'sd1;
  localparam score_t SC_ZERO       = 28'sd0;

  localparam logic [21:0] RATE_CAP = 22'd2999999;
  localparam logic [6:0]  TOL_TIGHT = 7'd10;
  localparam logic [6:0]  TOL_LOOSE = 7'd100;

endpackage

[sv/dmbm_score.sv]
// Scores one display mode against the target registers.
`timescale 1ns / 1ps

module dmbm_score import dmbm_pkg::*; (
  input  mode_t  mode,
  input  cfg_t   cfg,
  output score_t score
);

  logic [20:0] r_m;
  logic [20:0] r_f;
  logic [21:0] r_d;
  logic [21:0] capped;
  logic        size_ok;
  logic        il;
  logic        pref;
  score_t      rate_sc;
  score_t      s;

  function automatic logic near(input logic [22:0] a, input logic [22:0] b,
                                input logic [6:0] tol);
    logic [22:0] t;
    t = {16'd0, tol};
    return (a + t >= b) && (a <= b + t);
  endfunction

  assign il      = mode.mode_interlaced;
  assign pref    = mode.mode_preferred;
  assign size_ok = (mode.mode_width == cfg.target_width) &&
                   (mode.mode_height == cfg.target_height);

  // Field rate counts twice for interlaced scan, on both sides.
  assign r_m = il ? {mode.mode_rate, 1'b0} : {1'b0, mode.mode_rate};
  assign r_f = cfg.target_interlaced ? {cfg.target_rate, 1'b0} : {1'b0, cfg.target_rate};
  assign r_d = {r_f, 1'b0};
  assign capped = ({1'b0, r_m} >= RATE_CAP) ? RATE_CAP : {1'b0, r_m};

  always_comb begin
    priority if (r_f == 21'd0) begin
      rate_sc = pref ? SC_ANY_PREF : SC_ANY_BASE + score_t'(capped);
    end else if (near({2'b0, r_m}, {2'b0, r_f}, TOL_TIGHT)) begin
      rate_sc = SC_EXACT;
    end else if (near({2'b0, r_m}, {2'b0, r_f}, TOL_LOOSE)) begin
      rate_sc = SC_NEAR;
    end else if (near({2'b0, r_m}, {1'b0, r_d}, TOL_TIGHT)) begin
      rate_sc = SC_DBL_EXACT;
    end else if (near({2'b0, r_m}, {1'b0, r_d}, TOL_LOOSE)) begin
      rate_sc = SC_DBL_NEAR;
    end else begin
      rate_sc = SC_NONE;
    end
  end

  always_comb begin
    s = SC_NONE;
    unique case (rule_t'(cfg.scoring_rule))
      RULE_PROGRESSIVE: begin
        if (size_ok && !il) s = rate_sc;
        // Size penalty cannot fire: a positive score implies a size match.
        if (s > SC_ZERO && !size_ok) s = s - SC_SIZE_PEN;
        if (s <= SC_ZERO && pref) s = SC_PREF_FLOOR;
      end
      RULE_PREFERRED: begin
        s = pref ? SC_ONE : SC_ZERO;
      end
      RULE_INTERLACE: begin
        if (size_ok) s = rate_sc;
        if (s > SC_ZERO && !size_ok) s = s - SC_SIZE_PEN;
        if (il != cfg.target_interlaced) s = s - SC_SCAN_PEN;
        if (s <= SC_ZERO && pref) s = SC_PREF_FLOOR;
      end
      default: s = SC_NONE;
    endcase
  end

  assign score = s;

endmodule

[sv/display_mode_best_match_picker.sv]
// Top level of the display mode best-match picker.
`timescale 1ns / 1ps

// Display mode best-match picker. Feed the modes of a list one word per
// cycle on the in_ channel, the final mode flagged with last_mode; for each
// list one result word comes out on the out_ channel carrying the index of
// the highest scoring mode (the earliest one on a tie) and its score, or -1
// for both when no mode scored above -1. A mode of width 0 is an ordinary
// mode; only last_mode ends a list. Modes past MAX_MODES in a list are not
// scored, but a last mark among them still ends the list. The block takes
// one mode per clock unless a last mode waits behind an untaken result;
// the path is three registers deep (input word, score, running best with
// the result register), and the result word is loaded as the last mode
// leaves the score register. The only loop is the compare of the new score
// against the running best. Input keeps flowing while a result waits; only a
// second last mode stalls behind an untaken result. Program the target
// through the cfg_ port while the block is idle; cfg_ready is always high.

module display_mode_best_match_picker import dmbm_pkg::*; #(
  parameter int MAX_MODES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mode_t                 in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output result_t               out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_MODES + 1);

  // Target registers.
  cfg_t cfg_r;

  // Stage 1: registered mode word.
  logic  s1_valid_r;
  mode_t s1_r;

  // Stage 2: score of that mode.
  logic   s2_valid_r;
  logic   s2_last_r;
  score_t s2_score_r;
  score_t score;

  // Running best over the current list.
  score_t           lead_score_r;
  index_t           best_index_r;
  logic [CNT_W-1:0] cnt_r;

  // Result register.
  logic    out_valid_r;
  result_t out_r;

  logic   acc_take;
  logic   s2_ready;
  logic   s1_ready;
  logic   in_range;
  logic   win;
  score_t upd_score;
  index_t upd_index;

  // Configuration writes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TARGET_WIDTH:      cfg_r.target_width      <= cfg_data[DIM_W-1:0];
        CFG_TARGET_HEIGHT:     cfg_r.target_height     <= cfg_data[DIM_W-1:0];
        CFG_TARGET_RATE:       cfg_r.target_rate       <= cfg_data[RATE_W-1:0];
        CFG_TARGET_INTERLACED: cfg_r.target_interlaced <= cfg_data[0];
        CFG_SCORING_RULE:      cfg_r.scoring_rule      <= cfg_data[1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Flow control: a last mode may only enter the accumulator when the
  // result register is free or is being drained this cycle.
  assign acc_take = s2_valid_r && (!s2_last_r || !out_valid_r || out_ready);
  assign s2_ready = !s2_valid_r || acc_take;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage 1: hold the mode word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_r <= in_data;
    end
  end

  dmbm_score u_score (
    .mode  (s1_r),
    .cfg   (cfg_r),
    .score (score)
  );

  // Stage 2: hold the score and the list-end flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_score_r <= score;
      s2_last_r  <= s1_r.last_mode;
    end
  end

  // Accumulator: strictly greater wins, so the earliest mode keeps a tie.
  assign in_range  = cnt_r < CNT_W'(MAX_MODES);
  assign win       = in_range && (s2_score_r > lead_score_r);
  assign upd_score = win ? s2_score_r : lead_score_r;
  assign upd_index = win ? index_t'(IDX_W'(cnt_r)) : best_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_score_r <= SC_NONE;
      best_index_r <= '1;
      cnt_r        <= '0;
    end else if (acc_take) begin
      if (s2_last_r) begin
        // List ends: clear for the next one.
        lead_score_r <= SC_NONE;
        best_index_r <= '1;
        cnt_r        <= '0;
      end else begin
        lead_score_r <= upd_score;
        best_index_r <= upd_index;
        if (in_range) cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // Result register: load on a last mode, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_take && s2_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_take && s2_last_r) begin
      out_r.best_index <= upd_index;
      out_r.pick_score <= upd_score;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[sv/dmbm_checker.sv]
// Port-level checks for the display mode best-match picker, bound to the top level.
`timescale 1ns / 1ps

module dmbm_checker import dmbm_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input mode_t   in_data,
  input logic    out_valid,
  input logic    out_ready,
  input result_t out_data
);

  // A stalled mode word holds until taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("mode word changed or vanished before it was taken");

  // A pending result word holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or vanished before it was taken");

  // No score above -1 means no mode was picked.
  a_none_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pick_score == SC_NONE |-> out_data.best_index == '1)
    else $error("score -1 reported with a real mode index");

  // Scores stay within the tiers.
  a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pick_score <= SC_EXACT &&
                  out_data.pick_score >= SC_NONE - SC_SCAN_PEN)
    else $error("result score outside the scoring range");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

endmodule

bind display_mode_best_match_picker dmbm_checker u_dmbm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[test/display_mode_best_match_picker_tb.sv]
// Self-checking testbench for the display mode best-match picker.
`timescale 1ns / 1ps

// Check every pick word of the block against a predictor kept in this file.
//
// Run order:
//   - directed table: reset target, size and rate extremes, each rate tier,
//     each scoring rule including the unused selector, the preferred floor,
//     the scan-mismatch penalty, ties and zero-width modes. Where the pick is
//     obvious it is typed in the table; else the predictor supplies it.
//   - random phases: retarget while idle, then lists of random length whose
//     modes mostly match the target size with rates near the target, its
//     double, or anywhere. Two phases open with a list at or past the mode cap.
//
// Both sides pause at random before each word, except in steady phases where
// they run flat out. Once, the result side holds off long enough that the
// block stalls its input behind an untaken pick. Each retarget waits until
// every pick has drained, so the sender pauses with the pipe empty.
//
// A watchdog ends the run when no word moves on any channel for too long.

module display_mode_best_match_picker_tb;
  import dmbm_pkg::*;

  localparam int LIST_CAP        = 256;
  localparam int RANDOM_MODES    = 1320;
  localparam int LISTS_PER_PHASE = 10;
  // Margin after every pick has drained, before a retarget.
  localparam int SETTLE_CYCLES   = 5;
  localparam int DRAIN_CYCLES    = 8;
  // Hold off inside the first random phase, where short lists keep coming.
  localparam int HOLD_OFF_AT     = 14;
  localparam int HOLD_OFF_CYCLES = 80;
  // Longest correct quiet stretch is the hold-off plus settle; take it
  // many times over.
  localparam int QUIET_LIMIT     = 2000;
  localparam int REPORT_LIMIT    = 10;
  localparam logic [1:0] RULE_UNUSED = 2'd3;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  mode_t   in_data;
  logic    out_valid;
  logic    out_ready;
  result_t out_data;
  logic    cfg_valid;
  logic    cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  always #4 clk = ~clk;

  display_mode_best_match_picker #(.MAX_MODES(LIST_CAP)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Predictor state: target registers and the running best of the list.
  // ---------------------------------------------------------------------
  cfg_t    target        = '0;
  int      run_score     = -1;
  int      best_index    = -1;
  int      modes_in_list = 0;

  result_t picks_due[$];   // picks predicted, oldest first
  int      mismatches  = 0;
  int      picks_taken = 0;
  int      modes_sent  = 0;
  int      quiet_cycles = 0;
  bit      steady = 1'b0;  // no idle cycles on either side while set

  // One row of the directed table: either a retarget or a mode word.
  typedef struct {
    bit      retarget;
    cfg_t    target;
    mode_t   mode;
    bit      typed;
    result_t pick;
  } row_t;

  row_t plan[$];

  function automatic bit near_rate(longint r_m, longint center, longint tol);
    return (r_m + tol >= center) && (r_m <= center + tol);
  endfunction

  // Rate tier of one mode; r_m already doubled for an interlaced mode.
  function automatic int rate_tier(longint r_m, logic pref);
    longint r_f;
    longint r_d;
    r_f = target.target_rate;
    if (target.target_interlaced) r_f = r_f * 2;
    r_d = r_f * 2;
    // Zero target rate: take the preferred mode, else the fastest.
    if (r_f == 0) begin
      if (pref) return SC_ANY_PREF;
      return int'(SC_ANY_BASE) + int'(r_m >= RATE_CAP ? longint'(RATE_CAP) : r_m);
    end
    if (near_rate(r_m, r_f, TOL_TIGHT)) return SC_EXACT;
    if (near_rate(r_m, r_f, TOL_LOOSE)) return SC_NEAR;
    if (near_rate(r_m, r_d, TOL_TIGHT)) return SC_DBL_EXACT;
    if (near_rate(r_m, r_d, TOL_LOOSE)) return SC_DBL_NEAR;
    return SC_NONE;
  endfunction

  function automatic int mode_score(mode_t m);
    bit     size_ok;
    longint r_m;
    int     s;
    size_ok = (m.mode_width == target.target_width) &&
              (m.mode_height == target.target_height);
    r_m = m.mode_rate;
    if (m.mode_interlaced) r_m = r_m * 2;
    s = SC_NONE;
    case (target.scoring_rule)
      RULE_PROGRESSIVE: begin
        if (size_ok && !m.mode_interlaced) s = rate_tier(r_m, m.mode_preferred);
      end
      RULE_PREFERRED: begin
        return m.mode_preferred ? SC_ONE : SC_ZERO;
      end
      RULE_INTERLACE: begin
        if (size_ok) s = rate_tier(r_m, m.mode_preferred);
        if (m.mode_interlaced != target.target_interlaced) s = s - SC_SCAN_PEN;
      end
      default: begin
        return SC_NONE;
      end
    endcase
    // A positive tier needs a size match, so the size penalty never lands.
    if (s <= 0 && m.mode_preferred) s = SC_PREF_FLOOR;
    return s;
  endfunction

  // Advance the running best by one mode; return 1 with the pick on a last.
  function automatic bit list_step(input mode_t m, output result_t pick);
    int s;
    pick = '0;
    if (modes_in_list < LIST_CAP) begin
      s = mode_score(m);
      if (s > run_score) begin
        run_score = s;
        best_index = modes_in_list;
      end
      modes_in_list++;
    end
    if (!m.last_mode) return 1'b0;
    pick.best_index = index_t'(best_index);
    pick.pick_score = score_t'(run_score);
    run_score = SC_NONE;
    best_index = -1;
    modes_in_list = 0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table builders.
  // ---------------------------------------------------------------------
  function automatic void add_target(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                     logic [RATE_W-1:0] rate, logic il,
                                     logic [1:0] rule);
    row_t r;
    r = '{default: '0};
    r.retarget = 1'b1;
    r.target.target_width = w;
    r.target.target_height = h;
    r.target.target_rate = rate;
    r.target.target_interlaced = il;
    r.target.scoring_rule = rule;
    plan.push_back(r);
  endfunction

  function automatic void add_mode(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                   logic [RATE_W-1:0] rate, logic il, logic pref,
                                   logic last);
    row_t r;
    r = '{default: '0};
    r.mode.mode_width = w;
    r.mode.mode_height = h;
    r.mode.mode_rate = rate;
    r.mode.mode_interlaced = il;
    r.mode.mode_preferred = pref;
    r.mode.last_mode = last;
    plan.push_back(r);
  endfunction

  // Pin the pick of the list that the previous row closes.
  function automatic void add_pick(int idx, int score);
    plan[plan.size()-1].typed = 1'b1;
    plan[plan.size()-1].pick.best_index = index_t'(idx);
    plan[plan.size()-1].pick.pick_score = score_t'(score);
  endfunction

  // ---------------------------------------------------------------------
  // Random generators.
  // ---------------------------------------------------------------------
  function automatic cfg_t random_target(int phase);
    cfg_t t;
    int   pick;
    case (phase)
      0: begin
        t.target_width = '0;
        t.target_height = '0;
        t.target_rate = '0;
      end
      1: begin
        t.target_width = '1;
        t.target_height = '1;
        t.target_rate = '1;
      end
      default: begin
        t.target_width = DIM_W'($urandom);
        t.target_height = DIM_W'($urandom);
        pick = $urandom_range(0, 7);
        if (pick == 0) t.target_rate = '0;
        else if (pick == 1) t.target_rate = '1;
        else if (pick == 2) t.target_rate = RATE_W'($urandom_range(1, 150));
        else t.target_rate = RATE_W'($urandom);
      end
    endcase
    t.target_interlaced = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 7);
    if (pick < 3) t.scoring_rule = RULE_PROGRESSIVE;
    else if (pick < 6) t.scoring_rule = RULE_INTERLACE;
    else if (pick == 6) t.scoring_rule = RULE_PREFERRED;
    else t.scoring_rule = RULE_UNUSED;
    return t;
  endfunction

  // Mostly a size match with a rate aimed at a tier edge; some noise.
  function automatic mode_t random_mode(bit last);
    mode_t  m;
    longint r_f;
    longint eff;
    bit     raw;
    m.mode_width = target.target_width;
    m.mode_height = target.target_height;
    case ($urandom_range(0, 9))
      0: m.mode_width = DIM_W'($urandom);
      1: m.mode_height = DIM_W'($urandom);
      2: m.mode_width = '0;
      default: ;
    endcase
    m.mode_interlaced = 1'($urandom_range(0, 1));
    m.mode_preferred = ($urandom_range(0, 5) == 0);
    m.last_mode = last;
    r_f = target.target_rate;
    if (target.target_interlaced) r_f = r_f * 2;
    raw = 1'b0;
    eff = 0;
    case ($urandom_range(0, 4))
      0: eff = r_f + int'($urandom_range(0, 20)) - 10;
      1: eff = r_f + int'($urandom_range(0, 240)) - 120;
      2: eff = 2 * r_f + int'($urandom_range(0, 20)) - 10;
      3: eff = 2 * r_f + int'($urandom_range(0, 240)) - 120;
      default: raw = 1'b1;
    endcase
    if (raw) begin
      m.mode_rate = RATE_W'($urandom);
    end else begin
      // Halve so that the doubled interlaced rate lands near the aim.
      if (m.mode_interlaced) eff = eff / 2;
      if (eff < 0) eff = 0;
      if (eff > 64'h0_FFFFF) eff = 64'h0_FFFFF;
      m.mode_rate = eff[RATE_W-1:0];
    end
    return m;
  endfunction

  // ---------------------------------------------------------------------
  // Channel drivers.
  // ---------------------------------------------------------------------

  // Offer one mode word, hold it until taken, then predict.
  task automatic send_mode(input mode_t m, input bit typed, input result_t typed_pick);
    int      gap;
    result_t pick;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    modes_sent++;
    if (list_step(m, pick)) picks_due.push_back(typed ? typed_pick : pick);
  endtask

  // Drop valid and wait until every predicted pick has arrived.
  task automatic settle();
    in_valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leave cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all five registers with junk in the unused upper data bits.
  task automatic retarget(input cfg_t t);
    logic [CFG_DATA_W-1:0] junk;
    settle();
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_TARGET_WIDTH,      {junk[19:16], t.target_width});
    write_reg(CFG_TARGET_HEIGHT,     {junk[19:16], t.target_height});
    write_reg(CFG_TARGET_RATE,       t.target_rate);
    write_reg(CFG_TARGET_INTERLACED, {junk[19:1], t.target_interlaced});
    write_reg(CFG_SCORING_RULE,      {junk[19:2], t.scoring_rule});
    cfg_valid <= 1'b0;
    target = t;
  endtask

  // ---------------------------------------------------------------------
  // Result side: random ready, one long hold-off, in-order compare.
  // ---------------------------------------------------------------------
  initial begin : drain
    int      stall;
    result_t got;
    result_t want;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      // Hold off once so that a second last mode backs up the input.
      if (picks_taken == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = out_data;
      picks_taken++;
      if (picks_due.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected pick: index %0d score %0d", got.best_index, got.pick_score);
        mismatches++;
      end else begin
        want = picks_due.pop_front();
        if (got.best_index !== want.best_index || got.pick_score !== want.pick_score) begin
          if (mismatches < REPORT_LIMIT)
            $display("pick mismatch: index exp %0d got %0d, score exp %0d got %0d",
                     want.best_index, got.best_index, want.pick_score, got.pick_score);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int len;
    int phase;
    int random_start;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset target: zero size, any rate, progressive rule.
    add_mode(16'h0000, 16'h0000, 20'h00000, 1'b0, 1'b0, 1'b1);   // zero width scores
    add_pick(0, 80000000);
    add_mode(16'h0000, 16'h0000, 20'hFFFFF, 1'b1, 1'b0, 1'b0);   // interlaced rejected
    add_mode(16'h0000, 16'h0000, 20'hFFFFF, 1'b0, 1'b1, 1'b1);
    add_pick(1, 83000000);
    add_mode(16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b0, 1'b0, 1'b1);   // nothing scores
    add_pick(-1, -1);

    // Walk every rate tier upward; a tie at the end must not win.
    add_target(16'hFFFF, 16'hFFFF, 20'd60000, 1'b0, RULE_PROGRESSIVE);
    add_mode(16'hFFFF, 16'hFFFF, 20'd30000, 1'b1, 1'b0, 1'b0);
    add_mode(16'hFFFF, 16'hFFFF, 20'd120100, 1'b0, 1'b0, 1'b0);
    add_mode(16'hFFFF, 16'hFFFF, 20'd120000, 1'b0, 1'b0, 1'b0);
    add_mode(16'hFFFF, 16'hFFFF, 20'd60095, 1'b0, 1'b0, 1'b0);
    add_mode(16'hFFFF, 16'hFFFF, 20'd60005, 1'b0, 1'b0, 1'b0);
    add_mode(16'hFFFF, 16'hFFFF, 20'd60000, 1'b0, 1'b0, 1'b1);

    // Top rate with interlaced target; scan mismatch penalty.
    add_target(16'h0000, 16'h0000, 20'hFFFFF, 1'b1, RULE_INTERLACE);
    add_mode(16'h0000, 16'h0000, 20'hFFFFF, 1'b1, 1'b0, 1'b0);
    add_mode(16'h0000, 16'h0000, 20'hFFFFF, 1'b0, 1'b0, 1'b1);

    add_target(16'd1920, 16'd1080, 20'd30000, 1'b1, RULE_INTERLACE);
    add_mode(16'd1920, 16'd1080, 20'd60000, 1'b0, 1'b0, 1'b0);
    add_mode(16'd1920, 16'd1080, 20'd1, 1'b0, 1'b1, 1'b0);       // preferred floor
    add_mode(16'd1920, 16'd1080, 20'd30000, 1'b1, 1'b0, 1'b1);
    add_mode(16'd1280, 16'd720, 20'd30000, 1'b0, 1'b0, 1'b1);    // below -1, no pick
    add_pick(-1, -1);

    add_target(16'd1920, 16'd1080, 20'd60000, 1'b0, RULE_PREFERRED);
    add_mode(16'h0000, 16'h0000, 20'h00000, 1'b0, 1'b0, 1'b0);
    add_mode(16'h0000, 16'h0000, 20'h00000, 1'b0, 1'b1, 1'b0);
    add_mode(16'h0000, 16'h0000, 20'h00000, 1'b0, 1'b1, 1'b1);
    add_pick(1, 1);
    add_mode(16'h0000, 16'h0000, 20'h00000, 1'b0, 1'b0, 1'b1);
    add_pick(0, 0);

    // Unused selector never wins.
    add_target(16'd1920, 16'd1080, 20'd60000, 1'b0, RULE_UNUSED);
    add_mode(16'd1920, 16'd1080, 20'd60000, 1'b0, 1'b1, 1'b1);
    add_pick(-1, -1);

    // Progressive rule lifts a rejected preferred mode to the floor.
    add_target(16'd1920, 16'd1080, 20'd60000, 1'b0, RULE_PROGRESSIVE);
    add_mode(16'd1920, 16'd1080, 20'd60000, 1'b1, 1'b1, 1'b1);
    add_pick(0, 10000000);

    foreach (plan[k]) begin
      if (plan[k].retarget) retarget(plan[k].target);
      else send_mode(plan[k].mode, plan[k].typed, plan[k].pick);
    end

    // Random phases; two of them open with a list at or past the mode cap.
    random_start = modes_sent;
    phase = 0;
    while (modes_sent - random_start < RANDOM_MODES) begin
      retarget(random_target(phase));
      steady = (phase % 4 == 3);
      for (int n = 0; n < LISTS_PER_PHASE; n++) begin
        if ((phase == 1 || phase == 6) && n == 0) len = $urandom_range(LIST_CAP, LIST_CAP + 6);
        else len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) send_mode(random_mode(i == len - 1), 1'b0, '0);
      end
      phase++;
    end

    // Drain what is still in flight; the watchdog bounds this wait.
    in_valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[display_mode_best_match_picker.f]
sv/dmbm_pkg.sv
sv/dmbm_score.sv
sv/display_mode_best_match_picker.sv
sv/dmbm_checker.sv
test/display_mode_best_match_picker_tb.sv
